// ===== design/tenc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tenc_pkg
// Shared codes, constants and the queue entry type of the Thumb-1 encoder.
// ----------------------------------------------------------------------------
package tenc_pkg;

    // operand forms
    localparam logic [2:0] MODE_LABEL = 3'd0;
    localparam logic [2:0] MODE_RRR   = 3'd1;
    localparam logic [2:0] MODE_RRI   = 3'd2;
    localparam logic [2:0] MODE_RI    = 3'd3;
    localparam logic [2:0] MODE_RR    = 3'd4;
    localparam logic [2:0] MODE_R     = 3'd5;
    localparam logic [2:0] MODE_MEM   = 3'd6;

    // mnemonics
    localparam logic [4:0] MN_B    = 5'd0;
    localparam logic [4:0] MN_BL   = 5'd1;
    localparam logic [4:0] MN_ADD  = 5'd2;
    localparam logic [4:0] MN_SUB  = 5'd3;
    localparam logic [4:0] MN_LSL  = 5'd4;
    localparam logic [4:0] MN_LSR  = 5'd5;
    localparam logic [4:0] MN_ASR  = 5'd6;
    localparam logic [4:0] MN_MOV  = 5'd7;
    localparam logic [4:0] MN_CMP  = 5'd8;
    localparam logic [4:0] MN_AND  = 5'd9;
    localparam logic [4:0] MN_EOR  = 5'd10;
    localparam logic [4:0] MN_ADC  = 5'd11;
    localparam logic [4:0] MN_SBC  = 5'd12;
    localparam logic [4:0] MN_ROR  = 5'd13;
    localparam logic [4:0] MN_TST  = 5'd14;
    localparam logic [4:0] MN_NEG  = 5'd15;
    localparam logic [4:0] MN_CMN  = 5'd16;
    localparam logic [4:0] MN_ORR  = 5'd17;
    localparam logic [4:0] MN_MUL  = 5'd18;
    localparam logic [4:0] MN_BIC  = 5'd19;
    localparam logic [4:0] MN_MVN  = 5'd20;
    localparam logic [4:0] MN_BX   = 5'd21;
    localparam logic [4:0] MN_LDR  = 5'd22;
    localparam logic [4:0] MN_STR  = 5'd23;
    localparam logic [4:0] MN_LDRB = 5'd24;
    localparam logic [4:0] MN_STRB = 5'd25;
    localparam logic [4:0] MN_LDRH = 5'd26;
    localparam logic [4:0] MN_STRH = 5'd27;

    // relocation kinds
    localparam logic [1:0] RK_NONE  = 2'd0;
    localparam logic [1:0] RK_REL8  = 2'd1;
    localparam logic [1:0] RK_REL11 = 2'd2;
    localparam logic [1:0] RK_REL22 = 2'd3;

    // register numbers with special forms
    localparam logic [3:0] REG_SP = 4'd13;
    localparam logic [3:0] REG_PC = 4'd15;

    // long branch halves
    localparam logic [15:0] HW_BL_HI = 16'hF000;
    localparam logic [15:0] HW_BL_LO = 16'hF800;

    // one classified request waiting for the back end
    typedef struct packed {
        logic [15:0] hw;
        logic [1:0]  reloc;
        logic        accepted;
        logic        dual;      // long branch: second halfword follows
    } t_entry;

endpackage

`default_nettype wire

// ===== design/thumb_instruction_encoder_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// thumb_instruction_encoder_core
// Thumb-1 instruction encoder: request in, one or two halfwords out.
// ----------------------------------------------------------------------------
// Each request is checked and packed in the cycle it is accepted and
// written into a small queue (QUEUE_DEPTH entries); the back end takes one
// entry per cycle into the output register while the output is not stalled
// and no long-branch second halfword is pending. A BL gives two halfwords,
// which leave through the single output register one after the other.
// Input stall rises only when the queue is full; an accepted request
// passes through the queue and then the output register before its first
// halfword is presented on the output.
// Rejected requests give a single transaction with accepted low.
module thumb_instruction_encoder_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_stall,
    input  wire logic [2:0]   i_mode,
    input  wire logic [4:0]   i_mnemonic,
    input  wire logic         i_conditional,
    input  wire logic [3:0]   i_cond_code,
    input  wire logic [3:0]   i_dest_reg,
    input  wire logic [3:0]   i_src_reg,
    input  wire logic [3:0]   i_third_reg,
    input  wire logic signed [31:0] i_immediate,
    output logic              o_valid,
    input  wire logic         i_stall,
    output logic [15:0]       o_halfword,
    output logic [1:0]        o_reloc_kind,
    output logic              o_accepted,
    output logic              o_last_word
);
    import tenc_pkg::*;

    t_entry w_push_entry;
    t_entry w_head;
    logic   w_push;
    logic   w_pop;
    logic   w_full;
    logic   w_empty;

    tenc_front u_front (
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_mode        (i_mode),
        .i_mnemonic    (i_mnemonic),
        .i_conditional (i_conditional),
        .i_cond_code   (i_cond_code),
        .i_dest_reg    (i_dest_reg),
        .i_src_reg     (i_src_reg),
        .i_third_reg   (i_third_reg),
        .i_immediate   (32'(unsigned'(i_immediate))),
        .i_full        (w_full),
        .o_push        (w_push),
        .o_entry       (w_push_entry)
    );

    tenc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_push_entry),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    tenc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (w_head),
        .i_empty      (w_empty),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_halfword   (o_halfword),
        .o_reloc_kind (o_reloc_kind),
        .o_accepted   (o_accepted),
        .o_last_word  (o_last_word)
    );

endmodule

`default_nettype wire

// ===== design/tenc_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tenc_front
// Accepts requests, checks legality and packs the first halfword into an
// entry for the queue.
// ----------------------------------------------------------------------------
module tenc_front (
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [2:0]        i_mode,
    input  wire logic [4:0]        i_mnemonic,
    input  wire logic              i_conditional,
    input  wire logic [3:0]        i_cond_code,
    input  wire logic [3:0]        i_dest_reg,
    input  wire logic [3:0]        i_src_reg,
    input  wire logic [3:0]        i_third_reg,
    input  wire logic [31:0]       i_immediate,
    input  wire logic              i_full,
    output logic                   o_push,
    output tenc_pkg::t_entry       o_entry
);
    import tenc_pkg::*;

    logic [2:0]  w_rd;
    logic [2:0]  w_rs;
    logic [2:0]  w_rt;
    logic        w_lo2;
    logic        w_anyhi;
    logic [7:0]  w_hi;
    logic [8:0]  w_neg;
    logic        w_ok;
    logic [15:0] w_hw;
    logic [1:0]  w_rk;
    logic        w_dual;

    assign w_rd    = i_dest_reg[2:0];
    assign w_rs    = i_src_reg[2:0];
    assign w_rt    = i_third_reg[2:0];
    assign w_lo2   = !i_dest_reg[3] && !i_src_reg[3];
    assign w_anyhi = i_dest_reg[3] || i_src_reg[3];
    assign w_hi    = {i_dest_reg[3], i_src_reg[3], w_rs, w_rd};
    // only bits 8..2 of the negated SP adjustment are used
    assign w_neg   = 9'd0 - i_immediate[8:0];

    // legality check and first halfword
    always_comb begin
        w_ok   = 1'b0;
        w_hw   = 16'h0000;
        w_rk   = RK_NONE;
        w_dual = 1'b0;
        unique case (i_mode)
            MODE_LABEL: begin
                if (i_mnemonic == MN_B) begin
                    w_ok = 1'b1;
                    if (i_conditional) begin
                        w_hw = {4'hD, i_cond_code, 8'h00};
                        w_rk = RK_REL8;
                    end else begin
                        w_hw = 16'hE000;
                        w_rk = RK_REL11;
                    end
                end else if (i_mnemonic == MN_BL) begin
                    w_ok   = 1'b1;
                    w_hw   = HW_BL_HI;
                    w_rk   = RK_REL22;
                    w_dual = 1'b1;
                end
            end
            MODE_RRR: begin
                if ((i_mnemonic == MN_ADD || i_mnemonic == MN_SUB) && w_lo2
                        && !i_third_reg[3]) begin
                    w_ok = 1'b1;
                    w_hw = {6'b000110, (i_mnemonic == MN_SUB), w_rt, w_rs, w_rd};
                end
            end
            MODE_RRI: begin
                unique case (i_mnemonic)
                    MN_LSL, MN_LSR, MN_ASR: begin
                        if (w_lo2) begin
                            w_ok = 1'b1;
                            w_hw = {3'b000, i_mnemonic[1:0] ^ 2'b00,
                                    i_immediate[4:0], w_rs, w_rd};
                            // LSL 00, LSR 01, ASR 10
                            w_hw[12:11] = i_mnemonic[1:0] - 2'd0;
                            if (i_mnemonic == MN_LSL) w_hw[12:11] = 2'b00;
                            else if (i_mnemonic == MN_LSR) w_hw[12:11] = 2'b01;
                            else w_hw[12:11] = 2'b10;
                        end
                    end
                    MN_ADD: begin
                        if (i_src_reg == REG_PC) begin
                            w_ok = 1'b1;
                            w_hw = {5'b10100, w_rd, i_immediate[7:0]};
                        end else if (i_src_reg == REG_SP) begin
                            w_ok = 1'b1;
                            w_hw = {5'b10101, w_rd, i_immediate[7:0]};
                        end else if (w_lo2 && i_immediate[31:3] == '0) begin
                            w_ok = 1'b1;
                            w_hw = {7'b0001110, i_immediate[2:0], w_rs, w_rd};
                        end
                    end
                    MN_SUB: begin
                        if (w_lo2 && i_immediate[31:3] == '0) begin
                            w_ok = 1'b1;
                            w_hw = {7'b0001111, i_immediate[2:0], w_rs, w_rd};
                        end
                    end
                    default: ;
                endcase
            end
            MODE_RI: begin
                if (i_mnemonic == MN_ADD && i_dest_reg == REG_SP) begin
                    // SP adjust: sign picks add or subtract
                    w_ok = 1'b1;
                    if (!i_immediate[31]) w_hw = {9'b101100000, i_immediate[8:2]};
                    else                  w_hw = {9'b101100001, w_neg[8:2]};
                end else if ((i_mnemonic == MN_MOV || i_mnemonic == MN_CMP
                        || i_mnemonic == MN_ADD || i_mnemonic == MN_SUB)
                        && !i_dest_reg[3] && i_immediate[31:8] == '0) begin
                    w_ok = 1'b1;
                    if (i_mnemonic == MN_MOV)      w_hw = {5'b00100, w_rd, i_immediate[7:0]};
                    else if (i_mnemonic == MN_CMP) w_hw = {5'b00101, w_rd, i_immediate[7:0]};
                    else if (i_mnemonic == MN_ADD) w_hw = {5'b00110, w_rd, i_immediate[7:0]};
                    else                           w_hw = {5'b00111, w_rd, i_immediate[7:0]};
                end
            end
            MODE_RR: begin
                if (w_anyhi && (i_mnemonic == MN_ADD || i_mnemonic == MN_CMP
                        || i_mnemonic == MN_MOV)) begin
                    // hi-register forms
                    w_ok = 1'b1;
                    if (i_mnemonic == MN_ADD)      w_hw = {8'h44, w_hi};
                    else if (i_mnemonic == MN_CMP) w_hw = {8'h45, w_hi};
                    else                           w_hw = {8'h46, w_hi};
                end else if (w_lo2) begin
                    w_ok = 1'b1;
                    unique case (i_mnemonic)
                        MN_ADD:  w_hw = {7'b0001100, w_rs, w_rd, w_rd};
                        MN_SUB:  w_hw = {7'b0001101, w_rs, w_rd, w_rd};
                        MN_MOV:  w_hw = {10'h000, w_rs, w_rd};
                        MN_CMP:  w_hw = {10'h10A, w_rs, w_rd};
                        MN_AND:  w_hw = {10'h100, w_rs, w_rd};
                        MN_EOR:  w_hw = {10'h101, w_rs, w_rd};
                        MN_LSL:  w_hw = {10'h102, w_rs, w_rd};
                        MN_LSR:  w_hw = {10'h103, w_rs, w_rd};
                        MN_ASR:  w_hw = {10'h104, w_rs, w_rd};
                        MN_ADC:  w_hw = {10'h105, w_rs, w_rd};
                        MN_SBC:  w_hw = {10'h106, w_rs, w_rd};
                        MN_ROR:  w_hw = {10'h107, w_rs, w_rd};
                        MN_TST:  w_hw = {10'h108, w_rs, w_rd};
                        MN_NEG:  w_hw = {10'h109, w_rs, w_rd};
                        MN_CMN:  w_hw = {10'h10B, w_rs, w_rd};
                        MN_ORR:  w_hw = {10'h10C, w_rs, w_rd};
                        MN_MUL:  w_hw = {10'h10D, w_rs, w_rd};
                        MN_BIC:  w_hw = {10'h10E, w_rs, w_rd};
                        MN_MVN:  w_hw = {10'h10F, w_rs, w_rd};
                        default: w_ok = 1'b0;
                    endcase
                end
            end
            MODE_R: begin
                if (i_mnemonic == MN_BX && !i_dest_reg[3]) begin
                    w_ok = 1'b1;
                    w_hw = {10'h11C, w_rd, 3'b000};
                end
            end
            MODE_MEM: begin
                if ((i_mnemonic == MN_LDR || i_mnemonic == MN_STR)
                        && (i_src_reg == REG_SP
                            || (i_mnemonic == MN_LDR && i_src_reg == REG_PC))) begin
                    // SP- and PC-relative word access
                    if (!i_dest_reg[3] && i_immediate[31:10] == '0
                            && i_immediate[1:0] == 2'b00) begin
                        w_ok = 1'b1;
                        if (i_mnemonic == MN_STR)      w_hw = {5'b10010, w_rd, i_immediate[9:2]};
                        else if (i_src_reg == REG_PC)  w_hw = {5'b01001, w_rd, i_immediate[9:2]};
                        else                           w_hw = {5'b10011, w_rd, i_immediate[9:2]};
                    end
                end else if (w_lo2) begin
                    unique case (i_mnemonic)
                        MN_LDR, MN_STR: begin
                            if (i_immediate[31:7] == '0 && i_immediate[1:0] == 2'b00) begin
                                w_ok = 1'b1;
                                w_hw = {4'b0110, (i_mnemonic == MN_LDR),
                                        i_immediate[6:2], w_rs, w_rd};
                            end
                        end
                        MN_LDRB, MN_STRB: begin
                            if (i_immediate[31:5] == '0) begin
                                w_ok = 1'b1;
                                w_hw = {4'b0111, (i_mnemonic == MN_LDRB),
                                        i_immediate[4:0], w_rs, w_rd};
                            end
                        end
                        MN_LDRH, MN_STRH: begin
                            if (i_immediate[31:6] == '0 && !i_immediate[0]) begin
                                w_ok = 1'b1;
                                w_hw = {4'b1000, (i_mnemonic == MN_LDRH),
                                        i_immediate[5:1], w_rs, w_rd};
                            end
                        end
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
        // rejected requests carry nothing
        if (!w_ok) begin
            w_hw   = 16'h0000;
            w_rk   = RK_NONE;
            w_dual = 1'b0;
        end
    end

    assign o_stall          = i_full;
    assign o_push           = i_valid && !i_full;
    assign o_entry.hw       = w_hw;
    assign o_entry.reloc    = w_rk;
    assign o_entry.accepted = w_ok;
    assign o_entry.dual     = w_dual;

endmodule

`default_nettype wire

// ===== design/tenc_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tenc_queue
// Small FIFO of classified entries between the front and back ends.
// ----------------------------------------------------------------------------
module tenc_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire tenc_pkg::t_entry  i_entry,
    input  wire logic              i_pop,
    output tenc_pkg::t_entry       o_head,
    output logic                   o_full,
    output logic                   o_empty
);
    import tenc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

    t_entry           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    // pointer and occupancy update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        if (i_pop)  n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        if (i_push && !i_pop)      n_count = r_count + 1'b1;
        else if (!i_push && i_pop) n_count = r_count - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_entry;
    end

endmodule

`default_nettype wire

// ===== design/tenc_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tenc_back
// Pops entries and drives the output register; a long branch is sent as
// two transactions.
// ----------------------------------------------------------------------------
module tenc_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire tenc_pkg::t_entry  i_head,
    input  wire logic              i_empty,
    output logic                   o_pop,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic [15:0]            o_halfword,
    output logic [1:0]             o_reloc_kind,
    output logic                   o_accepted,
    output logic                   o_last_word
);
    import tenc_pkg::*;

    logic        r_valid;
    logic        r_pending;     // second long-branch halfword still to send
    logic [15:0] r_hw;
    logic [1:0]  r_rk;
    logic        r_acc;
    logic        r_last;
    logic        w_free;
    logic        w_load_second;
    logic        n_valid;
    logic        n_pending;

    assign w_free        = !r_valid || !i_stall;
    assign w_load_second = w_free && r_pending;
    assign o_pop         = w_free && !r_pending && !i_empty;

    // control: output valid and long-branch sequencing
    always_comb begin
        n_valid   = r_valid;
        n_pending = r_pending;
        if (w_load_second) begin
            n_valid   = 1'b1;
            n_pending = 1'b0;
        end else if (o_pop) begin
            n_valid   = 1'b1;
            n_pending = i_head.dual;
        end else if (w_free) begin
            n_valid   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_pending <= 1'b0;
        end else begin
            r_valid   <= n_valid;
            r_pending <= n_pending;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (w_load_second) begin
            r_hw   <= HW_BL_LO;
            r_rk   <= RK_NONE;
            r_acc  <= 1'b1;
            r_last <= 1'b1;
        end else if (o_pop) begin
            r_hw   <= i_head.hw;
            r_rk   <= i_head.reloc;
            r_acc  <= i_head.accepted;
            r_last <= !i_head.dual;
        end
    end

    assign o_valid      = r_valid;
    assign o_halfword   = r_hw;
    assign o_reloc_kind = r_rk;
    assign o_accepted   = r_acc;
    assign o_last_word  = r_last;

endmodule

`default_nettype wire

// ===== design/tenc_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tenc_checker
// Port-level checks on the encoder output, bound to the top level.
// ----------------------------------------------------------------------------
module tenc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [15:0] o_halfword,
    input wire logic [1:0]  o_reloc_kind,
    input wire logic        o_accepted,
    input wire logic        o_last_word
);
    import tenc_pkg::*;

    // stalled output transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_halfword)
            && $stable(o_reloc_kind) && $stable(o_accepted) && $stable(o_last_word)))
        else $error("output transaction changed while stalled");

    // rejection is a single empty transaction
    a_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_accepted) |-> (o_last_word && o_halfword == 16'h0000
            && o_reloc_kind == RK_NONE))
        else $error("malformed rejection");

    // only the first half of a long branch is not last
    a_bl_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last_word) |-> (o_accepted && o_halfword == HW_BL_HI
            && o_reloc_kind == RK_REL22))
        else $error("non-final halfword is not a long branch head");

    // the second half follows straight after the first is taken
    a_bl_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_last_word) |=> (o_valid && o_last_word
            && o_accepted && o_halfword == HW_BL_LO && o_reloc_kind == RK_NONE))
        else $error("long branch tail missing");

endmodule

bind thumb_instruction_encoder_core tenc_checker u_tenc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_halfword   (o_halfword),
    .o_reloc_kind (o_reloc_kind),
    .o_accepted   (o_accepted),
    .o_last_word  (o_last_word)
);

`default_nettype wire
